@@ sv/best_fit_heap_allocator_top_defines.svh @@
// Assertion macros for the best-fit heap allocator.
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// ante holds in a cycle, cons holds in the same cycle
`define BFHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in a cycle, cons holds in the following cycle
`define BFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bfha_pkg.sv @@
// Shared constants for the best-fit heap allocator.
`timescale 1ns / 1ps
package bfha_pkg;
	localparam int POOL_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 32;
	localparam int POOL_MIN         = 64;
	localparam int CFG_W            = 13;
	localparam int REQ_W            = 13;
	localparam int PADDR_W          = 12;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_FREE    = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOFIT = 1'b1;
endpackage

@@ sv/best_fit_heap_allocator_top.sv @@
// Best-fit heap allocator: block headers in memory, walked by a sequencer.
//
// Channels: requests enter on in_valid/in_ready (func, alloc_size, free_addr),
// results leave on out_valid/out_ready (payload_addr, status), one result per
// request. The user must write the pool size register with cfg_we and pool_size
// only while the block is idle; the block does not enforce it. A write clamps
// the value to 64..POOL_BYTES and rebuilds the pool as one free block.
// An allocate walks every block, one header read per cycle from the header memory,
// then writes the chosen block and, on a split, the new free block; a free walks
// to the block, then reads and merges both neighbours.
// One request is in work at a time; the next is taken as soon as the
// sequencer is idle, even while the last result still waits in the output
// register.
// Reset: asynchronous, active low; after release the pool is rebuilt, during
// which in_ready is low.
// Stall: while out_ready is low with a result held, a finished request
// waits in its final step and no further request is taken.
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_top_defines.svh"
module best_fit_heap_allocator_top #(
	parameter int POOL_BYTES   = bfha_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bfha_pkg::CFG_W-1:0]  pool_size,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [bfha_pkg::REQ_W-1:0]  alloc_size,
	input  logic [bfha_pkg::PADDR_W-1:0] free_addr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bfha_pkg::PADDR_W-1:0] payload_addr,
	output logic                        status
);
	localparam int IW = $clog2(POOL_BYTES);
	localparam int OW = $clog2(POOL_BYTES + 1);
	localparam int WW = ((OW > bfha_pkg::REQ_W) ? OW : bfha_pkg::REQ_W) + 1;
	localparam int SW = OW + 1;
	localparam int AW = bfha_pkg::PADDR_W;

	typedef logic [WW-1:0] wide_t;
	localparam wide_t HDR      = WW'(HEADER_BYTES);
	localparam wide_t POOL_MAX = WW'(POOL_BYTES);
	localparam wide_t POOL_LOW = WW'(bfha_pkg::POOL_MIN);

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_AWALK  = 4'd2;
	localparam logic [3:0] ST_AFIN   = 4'd3;
	localparam logic [3:0] ST_ASPL   = 4'd4;
	localparam logic [3:0] ST_FWALK  = 4'd5;
	localparam logic [3:0] ST_FRIGHT = 4'd6;
	localparam logic [3:0] ST_FLEFT  = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]    state_q;
	logic [OW-1:0] pool_q;
	logic [IW-1:0] off_q, best_q, nb_q, left_q;
	logic [OW-1:0] bsize_q, fsize_q, surplus_q;
	logic [OW-1:0] nxt_q, after_q;
	logic          found_q;
	logic [bfha_pkg::REQ_W-1:0] req_q;
	logic [AW-1:0] faddr_q;
	logic [AW-1:0] pend_addr_q;
	logic          pend_stat_q;
	logic          out_valid_q;
	logic [AW-1:0] out_addr_q;
	logic          out_stat_q;

	logic [SW-1:0] mem_sz [POOL_BYTES];
	logic [IW-1:0] mem_pv [POOL_BYTES];
	logic [SW-1:0] sz_rdata_q;
	logic [IW-1:0] pv_rdata_q;
	logic          sz_we, pv_we;
	logic [IW-1:0] sz_raddr, sz_waddr, pv_raddr, pv_waddr;
	logic [SW-1:0] sz_wdata;
	logic [IW-1:0] pv_wdata;

	wide_t cur_size, cur_nxt, pool_w, req_w, cfg_w, cfg_clamped;
	logic  cur_used;
	logic  fit, split, rmerge, hit, in_xfer;
	wide_t nb_w, s2_w, after2_w, lsum_w;
	logic [AW-1:0] hdr_addr;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign payload_addr = out_addr_q;
	assign status    = out_stat_q;

	assign cur_size = WW'(sz_rdata_q[OW-1:0]);
	assign cur_used = sz_rdata_q[OW];
	assign pool_w   = WW'(pool_q);
	assign req_w    = WW'(req_q);
	assign cur_nxt  = WW'(off_q) + HDR + cur_size;
	assign fit      = !cur_used && (cur_size >= req_w) &&
		(!found_q || (cur_size < WW'(bsize_q)));
	assign split    = WW'(bsize_q) > (req_w + HDR);
	assign nb_w     = WW'(best_q) + HDR + req_w;
	assign hdr_addr = AW'(WW'(off_q) + HDR);
	assign hit      = (hdr_addr == faddr_q) && cur_used;
	assign rmerge   = (WW'(nxt_q) < pool_w) && !cur_used;
	assign s2_w     = rmerge ? (WW'(fsize_q) + HDR + cur_size) : WW'(fsize_q);
	assign after2_w = WW'(off_q) + HDR + s2_w;
	assign lsum_w   = cur_size + HDR + WW'(fsize_q);
	assign cfg_w    = WW'(pool_size);

	always_comb begin
		if (cfg_w < POOL_LOW) begin
			cfg_clamped = POOL_LOW;
		end else if (cfg_w > POOL_MAX) begin
			cfg_clamped = POOL_MAX;
		end else begin
			cfg_clamped = cfg_w;
		end
	end

	// memory port control
	always_comb begin
		sz_raddr = off_q;
		pv_raddr = off_q;
		sz_we    = 1'b0;
		sz_waddr = off_q;
		sz_wdata = '0;
		pv_we    = 1'b0;
		pv_waddr = nb_q;
		pv_wdata = best_q;
		unique case (state_q)
			ST_INIT: begin
				sz_we    = 1'b1;
				sz_waddr = '0;
				sz_wdata = {1'b0, OW'(pool_w - HDR)};
			end
			ST_IDLE: begin
				sz_raddr = '0;
			end
			ST_AWALK: begin
				sz_raddr = IW'(cur_nxt);
			end
			ST_AFIN: begin
				if (found_q) begin
					sz_we    = 1'b1;
					sz_waddr = best_q;
					sz_wdata = {1'b1, split ? OW'(req_q) : bsize_q};
					pv_we    = split;
					pv_waddr = IW'(nb_w);
					pv_wdata = best_q;
				end
			end
			ST_ASPL: begin
				sz_we    = 1'b1;
				sz_waddr = nb_q;
				sz_wdata = {1'b0, surplus_q};
				pv_we    = WW'(after_q) < pool_w;
				pv_waddr = IW'(after_q);
				pv_wdata = nb_q;
			end
			ST_FWALK: begin
				sz_raddr = IW'(cur_nxt);
				pv_raddr = off_q;
			end
			ST_FRIGHT: begin
				sz_raddr = pv_rdata_q;
				sz_we    = 1'b1;
				sz_waddr = off_q;
				sz_wdata = {1'b0, OW'(s2_w)};
				pv_we    = rmerge && (after2_w < pool_w);
				pv_waddr = IW'(after2_w);
				pv_wdata = off_q;
			end
			ST_FLEFT: begin
				sz_we    = (off_q != '0) && !cur_used;
				sz_waddr = left_q;
				sz_wdata = {1'b0, OW'(lsum_w)};
				pv_we    = (off_q != '0) && !cur_used && (WW'(after_q) < pool_w);
				pv_waddr = IW'(after_q);
				pv_wdata = left_q;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sz_we) begin
			mem_sz[sz_waddr] <= sz_wdata;
		end
		if (pv_we) begin
			mem_pv[pv_waddr] <= pv_wdata;
		end
		sz_rdata_q <= mem_sz[sz_raddr];
		pv_rdata_q <= mem_pv[pv_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			pool_q      <= OW'(POOL_BYTES);
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				pool_q  <= OW'(cfg_clamped);
				state_q <= ST_INIT;
			end else begin
				unique case (state_q)
					ST_INIT: begin
						state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (in_xfer) begin
							off_q   <= '0;
							found_q <= 1'b0;
							req_q   <= alloc_size;
							faddr_q <= free_addr;
							state_q <= (func == bfha_pkg::FUNC_FREE) ? ST_FWALK : ST_AWALK;
						end
					end
					ST_AWALK: begin
						if (fit) begin
							best_q  <= off_q;
							bsize_q <= OW'(cur_size);
							found_q <= 1'b1;
						end
						if (cur_nxt < pool_w) begin
							off_q <= IW'(cur_nxt);
						end else begin
							state_q <= ST_AFIN;
						end
					end
					ST_AFIN: begin
						if (!found_q) begin
							pend_addr_q <= '0;
							pend_stat_q <= bfha_pkg::STATUS_NOFIT;
							state_q     <= ST_DONE;
						end else begin
							pend_addr_q <= AW'(WW'(best_q) + HDR);
							pend_stat_q <= bfha_pkg::STATUS_OK;
							nb_q        <= IW'(nb_w);
							surplus_q   <= OW'(WW'(bsize_q) - req_w - HDR);
							after_q     <= OW'(WW'(best_q) + HDR + WW'(bsize_q));
							state_q     <= split ? ST_ASPL : ST_DONE;
						end
					end
					ST_ASPL: begin
						state_q <= ST_DONE;
					end
					ST_FWALK: begin
						if (hit) begin
							fsize_q <= OW'(cur_size);
							nxt_q   <= OW'(cur_nxt);
							state_q <= ST_FRIGHT;
						end else if (cur_nxt < pool_w) begin
							off_q <= IW'(cur_nxt);
						end else begin
							pend_addr_q <= '0;
							pend_stat_q <= bfha_pkg::STATUS_OK;
							state_q     <= ST_DONE;
						end
					end
					ST_FRIGHT: begin
						fsize_q <= OW'(s2_w);
						after_q <= OW'(after2_w);
						left_q  <= pv_rdata_q;
						state_q <= ST_FLEFT;
					end
					ST_FLEFT: begin
						pend_addr_q <= '0;
						pend_stat_q <= bfha_pkg::STATUS_OK;
						state_q     <= ST_DONE;
					end
					ST_DONE: begin
						if (!out_valid_q || out_ready) begin
							out_addr_q  <= pend_addr_q;
							out_stat_q  <= pend_stat_q;
							state_q     <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	`BFHA_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "second request taken")
	`BFHA_ASSERT_NOW(a_fail_zero, out_valid && (status == bfha_pkg::STATUS_NOFIT),
		payload_addr == '0, "failed allocate with non-zero offset")
	`BFHA_ASSERT_NOW(a_split_right, state_q == ST_ASPL, nb_q > best_q,
		"split block not right of its parent")
	`BFHA_ASSERT_NEXT(a_init_blocks, state_q == ST_INIT && !cfg_we, in_ready,
		"pool rebuild did not end")
endmodule

@@ dv/tb_best_fit_heap_allocator_top.sv @@
// Self-checking testbench for the best-fit heap allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_best_fit_heap_allocator_top;
	localparam int HDR = bfha_pkg::HEADER_BYTES_DEF;
	localparam int POOL_MAX = bfha_pkg::POOL_BYTES_DEF;
	localparam int AW = bfha_pkg::PADDR_W;
	localparam int RW = bfha_pkg::REQ_W;
	localparam int CW = bfha_pkg::CFG_W;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [AW-1:0] addr;
		logic          st;
	} grant_t;

	typedef struct {
		logic                f;
		int                  sz;
		int                  ad;
		bit                  typed;
		int                  ea;
		logic                es;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CW-1:0]       pool_size = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = bfha_pkg::FUNC_ALLOC;
	logic [RW-1:0]       alloc_size = '0;
	logic [AW-1:0]       free_addr = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [AW-1:0]       payload_addr;
	logic                status;

	int unsigned blk_len [POOL_MAX];
	bit          blk_busy [POOL_MAX];
	int unsigned blk_left [POOL_MAX];
	int unsigned pool_live;

	grant_t grants_due [$];
	int     live_addrs [$];
	int     mismatches = 0;
	int     cycles = 0;
	int     stall_left = 0;
	bit     calm = 1'b0;

	best_fit_heap_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .pool_size(pool_size),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.alloc_size(alloc_size), .free_addr(free_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_addr(payload_addr), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void rebuild_pool(input int unsigned bytes);
		for (int i = 0; i < POOL_MAX; i++) begin
			blk_len[i] = 0;
			blk_busy[i] = 1'b0;
			blk_left[i] = 0;
		end
		pool_live = bytes;
		blk_len[0] = bytes - HDR;
	endfunction

	function automatic int unsigned follow(input int unsigned off);
		return off + HDR + blk_len[off];
	endfunction

	function automatic grant_t predict_grant(input logic f, input int unsigned req,
			input int unsigned addr);
		grant_t g;
		int unsigned off, best, nb, after, lft;
		bit found;
		g.addr = '0;
		g.st = bfha_pkg::STATUS_OK;
		off = 0;
		best = 0;
		found = 1'b0;
		if (f == bfha_pkg::FUNC_ALLOC) begin
			while (off < pool_live) begin
				if (!blk_busy[off] && blk_len[off] >= req &&
						(!found || blk_len[off] < blk_len[best])) begin
					best = off;
					found = 1'b1;
				end
				off = follow(off);
			end
			if (!found) begin
				g.st = bfha_pkg::STATUS_NOFIT;
				return g;
			end
			blk_busy[best] = 1'b1;
			if (blk_len[best] > req + HDR) begin
				nb = best + HDR + req;
				blk_len[nb] = blk_len[best] - req - HDR;
				blk_busy[nb] = 1'b0;
				blk_left[nb] = best;
				blk_len[best] = req;
				after = follow(nb);
				if (after < pool_live)
					blk_left[after] = nb;
			end
			g.addr = AW'((best + HDR) & 12'hFFF);
			return g;
		end
		while (off < pool_live) begin
			if (((off + HDR) & 12'hFFF) == addr && blk_busy[off])
				break;
			off = follow(off);
		end
		if (off >= pool_live)
			return g;
		blk_busy[off] = 1'b0;
		nb = follow(off);
		if (nb < pool_live && !blk_busy[nb]) begin
			after = follow(nb);
			blk_len[off] += HDR + blk_len[nb];
			if (after < pool_live)
				blk_left[after] = off;
		end
		if (off != 0) begin
			lft = blk_left[off];
			if (lft < POOL_MAX && !blk_busy[lft]) begin
				after = follow(off);
				blk_len[lft] += HDR + blk_len[off];
				if (after < pool_live)
					blk_left[after] = lft;
			end
		end
		return g;
	endfunction

	function automatic int pick_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 2);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_request(input logic f, input int sz, input int ad, input bit typed,
			input int ea, input logic es);
		int gap;
		grant_t g;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		alloc_size <= sz[RW-1:0];
		free_addr <= ad[AW-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g = predict_grant(f, sz & 13'h1FFF, ad & 12'hFFF);
		if (f == bfha_pkg::FUNC_ALLOC && g.st == bfha_pkg::STATUS_OK)
			live_addrs.push_back(int'(g.addr));
		if (f == bfha_pkg::FUNC_FREE)
			foreach (live_addrs[i])
				if (live_addrs[i] == ad) begin
					live_addrs.delete(i);
					break;
				end
		if (typed) begin
			g.addr = ea[AW-1:0];
			g.st = es;
		end
		grants_due.push_back(g);
	endtask

	task automatic write_pool(input int v);
		int unsigned b;
		in_valid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		pool_size <= v[CW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		b = v & 13'h1FFF;
		if (b < bfha_pkg::POOL_MIN)
			b = bfha_pkg::POOL_MIN;
		if (b > POOL_MAX)
			b = POOL_MAX;
		if (b < HDR)
			b = HDR;
		rebuild_pool(b);
		live_addrs.delete();
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) < 3) begin
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
				: $urandom_range(10, 60);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: addr %0d status %0d", payload_addr, status);
			end else begin
				want = grants_due.pop_front();
				if (payload_addr !== want.addr || status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
							want.addr, want.st, payload_addr, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_best_fit_heap_allocator_top failed");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		int cfg_vals [$];
		int kind, sz, ad;
		rows = '{
			'{bfha_pkg::FUNC_ALLOC, 4096, 0,    1, 0,  bfha_pkg::STATUS_NOFIT},
			'{bfha_pkg::FUNC_ALLOC, 4064, 0,    1, 32, bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 0,    0,    1, 0,  bfha_pkg::STATUS_NOFIT},
			'{bfha_pkg::FUNC_FREE,  0,    32,   1, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_FREE,  0,    32,   1, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_FREE,  0,    4095, 1, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 0,    0,    1, 32, bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 100,  0,    1, 64, bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 50,   0,    0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 200,  0,    0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_FREE,  0,    64,   0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 30,   0,    0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_FREE,  0,    32,   0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_FREE,  0,    0,    1, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 4096, 0,    1, 0,  bfha_pkg::STATUS_NOFIT},
			'{bfha_pkg::FUNC_ALLOC, 8191, 0,    1, 0,  bfha_pkg::STATUS_NOFIT},
			'{bfha_pkg::FUNC_ALLOC, 3000, 0,    0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_FREE,  0,    2730, 0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 31,   0,    0, 0,  bfha_pkg::STATUS_OK},
			'{bfha_pkg::FUNC_ALLOC, 33,   0,    0, 0,  bfha_pkg::STATUS_OK}
		};
		cfg_vals = '{0, 64, 8191, 63, 100, 4096, $urandom_range(65, 4095), 300};
		rebuild_pool(POOL_MAX);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i])
			send_request(rows[i].f, rows[i].sz, rows[i].ad, rows[i].typed,
				rows[i].ea, rows[i].es);
		foreach (cfg_vals[p]) begin
			write_pool(cfg_vals[p]);
			calm = (p % 3 == 2);
			for (int n = 0; n < 155; n++) begin
				kind = $urandom_range(0, 99);
				if (kind < 55 || live_addrs.size() == 0) begin
					if ($urandom_range(0, 49) == 0)
						sz = 4096;
					else if ($urandom_range(0, 3) == 0)
						sz = $urandom_range(0, pool_live);
					else
						sz = $urandom_range(0, 128);
					send_request(bfha_pkg::FUNC_ALLOC, sz, $urandom_range(0, 4095), 0, 0,
						bfha_pkg::STATUS_OK);
				end else if (kind < 94) begin
					ad = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
					send_request(bfha_pkg::FUNC_FREE, $urandom_range(0, 8191), ad, 0, 0,
						bfha_pkg::STATUS_OK);
				end else begin
					send_request(bfha_pkg::FUNC_FREE, $urandom_range(0, 8191),
						$urandom_range(0, 4095), 0, 0, bfha_pkg::STATUS_OK);
				end
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb_best_fit_heap_allocator_top passed");
		else
			$display("tb_best_fit_heap_allocator_top failed");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+sv
sv/bfha_pkg.sv
sv/best_fit_heap_allocator_top.sv
dv/tb_best_fit_heap_allocator_top.sv
